// ===== rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Types, constants and codes shared by the acceptor table modules.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int SLOTS     = 1024;
    localparam int MAX_RANGE = 64;
    localparam int PEERS     = 16;

    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int WALK_W  = $clog2(MAX_RANGE + 1);

    typedef enum logic [1:0] {
        OP_PREPARE    = 2'd0,
        OP_ACCEPT     = 2'd1,
        OP_RETRANSMIT = 2'd2,
        OP_DELIVER    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_PROMISE = 2'd0,
        K_REJECT  = 2'd1,
        K_LEARN   = 2'd2,
        K_RELEARN = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] instance_req;
        logic [31:0] range_end;
        logic [31:0] ballot;
        logic [63:0] value;
        logic [3:0]  peer;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_instance;
        logic [31:0] out_ballot;
        logic [31:0] value_ballot;
        logic [63:0] out_value;
        logic        has_value;
        logic        final_res;
        logic        broadcast;
        logic [3:0]  dest_peer;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] inst;
        logic [31:0] promised;
        logic [31:0] vballot;
        logic        has_value;
        logic [63:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_WREAD,
        ST_WEVAL,
        ST_WFLUSH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic cap;
        logic rd_look;
        logic commit;
        logic walk_init;
        logic rd_walk;
        logic walk_eval;
        logic walk_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_walk;
        logic range_empty;
        logic emits;
        logic out_free;
        logic walk_match;
        logic pend_valid;
        logic walk_end;
    } sts_t;

endpackage

// ===== rtl/pat_ram.sv =====
// ----------------------------------------------------------------------------
// pat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pat_datapath.sv =====
// ----------------------------------------------------------------------------
// pat_datapath
// Request register, slot memory, finalized instance, walk counter and
// result registers.
// ----------------------------------------------------------------------------
module pat_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  pat_pkg::cmd_t cmd,
    output pat_pkg::sts_t sts,
    input  pat_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pat_pkg::res_t m_data
);

    pat_pkg::req_t                   req_reg;
    logic [31:0]                     fin_reg, fin_next;
    logic [pat_pkg::SLOT_AW-1:0]     clr_reg;
    logic [pat_pkg::WALK_W-1:0]      idx_reg, idx_next, lasti_reg, lasti_next;
    pat_pkg::res_t                   pend_reg, out_reg, out_next;
    logic                            pend_valid_reg, out_valid_reg;

    logic                            we, re, emit;
    logic [pat_pkg::SLOT_AW-1:0]     waddr, raddr;
    pat_pkg::slot_t                  wrec, rd;
    logic [31:0]                     cur, span, pb, vb;
    logic [63:0]                     v;
    logic                            holds, hv, reject, same, is_pa, fin_hit, match;
    pat_pkg::res_t                   exec_res, walk_res;

    pat_ram #(
        .WIDTH ($bits(pat_pkg::slot_t)),
        .DEPTH (pat_pkg::SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrec),
        .re    (re),
        .raddr (raddr),
        .rdata (rd)
    );

    assign cur     = req_reg.instance_req + 32'(idx_reg);
    assign span    = req_reg.range_end - req_reg.instance_req;
    assign is_pa   = (req_reg.operation == pat_pkg::OP_PREPARE)
                  || (req_reg.operation == pat_pkg::OP_ACCEPT);
    assign fin_hit = req_reg.instance_req <= fin_reg;

    always_comb begin
        holds  = rd.valid && (rd.inst == req_reg.instance_req);
        pb     = holds ? rd.promised  : req_reg.ballot;
        vb     = holds ? rd.vballot   : 32'd0;
        hv     = holds ? rd.has_value : 1'b0;
        v      = holds ? rd.value     : 64'd0;
        reject = req_reg.ballot < pb;
        same   = holds && rd.has_value && (rd.value == req_reg.value);
        match  = rd.valid && (rd.inst == cur) && rd.has_value;
    end

    // slot write
    always_comb begin
        wrec           = '0;
        wrec.valid     = 1'b1;
        wrec.inst      = req_reg.instance_req;
        wrec.promised  = req_reg.ballot;
        we             = 1'b0;
        waddr          = req_reg.instance_req[pat_pkg::SLOT_AW-1:0];
        if (cmd.clr_step) begin
            wrec  = '0;
            waddr = clr_reg;
            we    = 1'b1;
        end else if (cmd.commit) begin
            case (req_reg.operation)
                pat_pkg::OP_PREPARE: begin
                    we             = !fin_hit && !reject;
                    wrec.vballot   = vb;
                    wrec.has_value = hv;
                    wrec.value     = hv ? v : 64'd0;
                end
                pat_pkg::OP_ACCEPT: begin
                    we             = !fin_hit && !reject;
                    wrec.vballot   = req_reg.ballot;
                    wrec.has_value = 1'b1;
                    wrec.value     = req_reg.value;
                end
                pat_pkg::OP_DELIVER: begin
                    we             = !same;
                    wrec.vballot   = req_reg.ballot;
                    wrec.has_value = 1'b1;
                    wrec.value     = req_reg.value;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign re    = cmd.rd_look || cmd.rd_walk;
    assign raddr = cmd.rd_walk ? cur[pat_pkg::SLOT_AW-1:0]
                               : req_reg.instance_req[pat_pkg::SLOT_AW-1:0];

    // result for prepare and accept
    always_comb begin
        exec_res              = '0;
        exec_res.out_instance = req_reg.instance_req;
        exec_res.final_res    = fin_hit;
        exec_res.last         = 1'b1;
        if (reject) begin
            exec_res.kind       = pat_pkg::K_REJECT;
            exec_res.out_ballot = pb;
            exec_res.dest_peer  = req_reg.peer;
        end else if (req_reg.operation == pat_pkg::OP_PREPARE) begin
            exec_res.kind         = pat_pkg::K_PROMISE;
            exec_res.out_ballot   = req_reg.ballot;
            exec_res.value_ballot = vb;
            exec_res.out_value    = hv ? v : 64'd0;
            exec_res.has_value    = hv;
            exec_res.dest_peer    = req_reg.peer;
        end else begin
            exec_res.kind       = pat_pkg::K_LEARN;
            exec_res.out_ballot = req_reg.ballot;
            exec_res.out_value  = req_reg.value;
            exec_res.has_value  = 1'b1;
            exec_res.broadcast  = 1'b1;
        end
    end

    always_comb begin
        walk_res              = '0;
        walk_res.kind         = pat_pkg::K_RELEARN;
        walk_res.out_instance = cur;
        walk_res.out_ballot   = rd.vballot;
        walk_res.out_value    = rd.value;
        walk_res.has_value    = 1'b1;
        walk_res.final_res    = cur <= fin_reg;
        walk_res.dest_peer    = req_reg.peer;
    end

    // result register load
    always_comb begin
        emit     = 1'b0;
        out_next = pend_reg;
        if (cmd.commit && is_pa && !fin_hit) begin
            emit     = 1'b1;
            out_next = exec_res;
        end else if (cmd.walk_eval && match && pend_valid_reg) begin
            emit = 1'b1;
        end else if (cmd.flush && pend_valid_reg) begin
            emit          = 1'b1;
            out_next.last = 1'b1;
        end
    end

    always_comb begin
        fin_next = fin_reg;
        if (cmd.commit && (req_reg.operation == pat_pkg::OP_DELIVER)) begin
            fin_next = req_reg.instance_req;
        end
        idx_next   = idx_reg;
        lasti_next = lasti_reg;
        if (cmd.walk_init) begin
            idx_next = '0;
            if (span >= 32'(pat_pkg::MAX_RANGE)) begin
                lasti_next = pat_pkg::WALK_W'(pat_pkg::MAX_RANGE - 1);
            end else begin
                lasti_next = span[pat_pkg::WALK_W-1:0];
            end
        end else if (cmd.walk_step) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg        <= '0;
            clr_reg        <= '0;
            idx_reg        <= '0;
            lasti_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
            lasti_reg <= lasti_next;
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.walk_eval && match) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            req_reg <= s_data;
        end
        if (cmd.walk_eval && match) begin
            pend_reg <= walk_res;
        end
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sts.clr_done    = &clr_reg;
    assign sts.is_walk     = req_reg.operation == pat_pkg::OP_RETRANSMIT;
    assign sts.range_empty = req_reg.range_end < req_reg.instance_req;
    assign sts.emits       = is_pa && !fin_hit;
    assign sts.out_free    = !out_valid_reg || m_ready;
    assign sts.walk_match  = match;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.walk_end    = idx_reg == lasti_reg;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");
    a_fin_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (fin_reg != $past(fin_reg)))
        |-> $past(cmd.commit && (req_reg.operation == pat_pkg::OP_DELIVER)))
        else $error("finalized instance changed outside a delivery");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= lasti_reg)
        else $error("walk index beyond range");
`endif

endmodule

// ===== rtl/pat_ctrl.sv =====
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer: memory clear, request decode, slot update and range walk.
// ----------------------------------------------------------------------------
module pat_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pat_pkg::sts_t sts,
    output pat_pkg::cmd_t cmd
);

    pat_pkg::state_t state_reg, state_next;
    logic            proceed;

    always_comb begin
        proceed = 1'b1;
        case (state_reg)
            pat_pkg::ST_EXEC:   proceed = !sts.emits || sts.out_free;
            pat_pkg::ST_WEVAL:  proceed = !sts.walk_match || !sts.pend_valid || sts.out_free;
            pat_pkg::ST_WFLUSH: proceed = !sts.pend_valid || sts.out_free;
            default:            proceed = 1'b1;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pat_pkg::ST_CLEAR: begin
                if (sts.clr_done) state_next = pat_pkg::ST_IDLE;
            end
            pat_pkg::ST_IDLE: begin
                if (s_valid) state_next = pat_pkg::ST_DECODE;
            end
            pat_pkg::ST_DECODE: begin
                if (!sts.is_walk)         state_next = pat_pkg::ST_EXEC;
                else if (sts.range_empty) state_next = pat_pkg::ST_IDLE;
                else                      state_next = pat_pkg::ST_WREAD;
            end
            pat_pkg::ST_EXEC: begin
                if (proceed) state_next = pat_pkg::ST_IDLE;
            end
            pat_pkg::ST_WREAD: begin
                state_next = pat_pkg::ST_WEVAL;
            end
            pat_pkg::ST_WEVAL: begin
                if (proceed) begin
                    state_next = sts.walk_end ? pat_pkg::ST_WFLUSH : pat_pkg::ST_WREAD;
                end
            end
            pat_pkg::ST_WFLUSH: begin
                if (proceed) state_next = pat_pkg::ST_IDLE;
            end
            default: begin
                state_next = pat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            pat_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
            pat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.cap = s_valid;
            end
            pat_pkg::ST_DECODE: begin
                cmd.rd_look   = !sts.is_walk;
                cmd.walk_init = sts.is_walk && !sts.range_empty;
            end
            pat_pkg::ST_EXEC:  cmd.commit  = proceed;
            pat_pkg::ST_WREAD: cmd.rd_walk = 1'b1;
            pat_pkg::ST_WEVAL: begin
                cmd.walk_eval = proceed;
                cmd.walk_step = proceed && !sts.walk_end;
            end
            pat_pkg::ST_WFLUSH: cmd.flush = proceed;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pat_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/paxos_acceptor_table_top.sv =====
// ----------------------------------------------------------------------------
// paxos_acceptor_table_top
// Paxos acceptor over a ring of instance slots held in one memory.
//
//   channel   ports                      moves
//   input     s_valid s_ready s_data     one request
//   result    m_valid m_ready m_data     one promise, reject, learn or relearn
//
// prepare, accept and delivered value pass through the decode and execute states after acceptance
// retransmit reads, then evaluates, each walked slot in turn, walked slots capped at MAX_RANGE,
// the read and evaluate states split by the registered read of the slot memory
// after reset a clearing pass over all SLOTS slots runs before the first request
// a stalled result register holds the sequencer until the result is taken
// ----------------------------------------------------------------------------
module paxos_acceptor_table_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pat_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pat_pkg::res_t m_data
);

    pat_pkg::cmd_t cmd;
    pat_pkg::sts_t sts;

    pat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pat_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
